### hw/rtl/slt_pkg.sv
// shared types and constants for the sorted label table
`timescale 1ns / 1ps

package slt_pkg;

   // fixed item field widths
   localparam int KEY_BITS      = 32;
   localparam int POS_BITS      = 9;
   localparam int COUNT_BITS    = 9;
   localparam int STATUS_BITS   = 2;
   localparam int RSP_DATA_BITS = 24;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2
   } slt_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_DECIDE,
      ST_SHIFT,
      ST_KEY,
      ST_FINISH
   } slt_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic srch_issue;
      logic srch_cmp;
      logic srch_miss;
      logic mark_dup;
      logic mark_full;
      logic shift_init;
      logic shift_step;
      logic key_write;
      logic rsp_load;
   } slt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_open;
      logic cmp_hit;
      logic mode_ins;
      logic is_hit;
      logic table_full;
      logic shift_done;
      logic out_free;
   } slt_stat_type;

endpackage

### hw/rtl/sorted_label_table_top.sv
// a lookup runs a binary search of at most log2(entries)+1 steps, each a registered read of the
// middle entry (SEARCH) and a compare (COMPARE); a hit ends the search at once
// an insert then shifts the entries above the insert position up, one entry a cycle, and writes
// the key (KEY); a rejected insert costs the same as a lookup
// one item in flight at a time; the next item is accepted while the result waits in the output
// register; synchronous active-high reset empties the table, memory not cleared
`timescale 1ns / 1ps

module sorted_label_table_top #(
   parameter int TABLE_DEPTH = 256,
   parameter int LABEL_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slt_pkg::KEY_BITS-1:0]      req_tdata,   // [31:0] key_label
   input  logic                              req_tuser,   // [0] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // [8:0] position, [10:9] status,
                                                          // [19:11] entry_count, rest zero
   output logic                              rsp_tuser    // [0] found
);
   import slt_pkg::*;

   slt_cmd_type  cmd;
   slt_stat_type stat;

   slt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   slt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LABEL_BITS  (LABEL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### hw/rtl/slt_datapath.sv
// datapath of the sorted label table: label memory, search bounds, shift pointer, output register
`timescale 1ns / 1ps

module slt_datapath #(
   parameter int TABLE_DEPTH = 256,
   parameter int LABEL_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  slt_pkg::slt_cmd_type                 cmd,
   output slt_pkg::slt_stat_type                stat,
   input  logic [slt_pkg::KEY_BITS-1:0]         req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [slt_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                 rsp_tuser
);
   import slt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic [LABEL_BITS-1:0] label_mem [TABLE_DEPTH];

   logic [LABEL_BITS-1:0] key_ff, key_in;
   logic                  mode_ff, mode_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         mid_ff, mid_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic                  hit_ff, hit_in;
   slt_status_type        status_ff, status_in;
   logic [CW-1:0]         used_ff, used_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         wdst_ff, wdst_in;
   logic                  pend_ff, pend_in;
   logic [LABEL_BITS-1:0] rd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [POS_BITS-1:0]   rsp_pos_ff, rsp_pos_in;
   slt_status_type        rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic [CW-1:0]         mid_calc;
   logic [CW-1:0]         shift_src;
   logic                  shift_go;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [LABEL_BITS-1:0] wr_data;

   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign shift_src = idx_ff - CW'(1);
   assign shift_go  = idx_ff > pos_ff;

   assign rd_addr = cmd.srch_issue ? mid_calc[AW-1:0] : shift_src[AW-1:0];
   assign wr_en   = (cmd.shift_step & pend_ff) | cmd.key_write;
   assign wr_addr = cmd.key_write ? pos_ff[AW-1:0] : wdst_ff[AW-1:0];
   assign wr_data = cmd.key_write ? key_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         label_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= label_mem[rd_addr];
   end

   always_comb begin
      key_in        = key_ff;
      mode_in       = mode_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      pos_in        = pos_ff;
      hit_in        = hit_ff;
      status_in     = status_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      wdst_in       = wdst_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.load) begin
         key_in    = LABEL_BITS'(req_tdata);
         mode_in   = req_tuser;
         lo_in     = '0;
         hi_in     = used_ff;
         hit_in    = 1'b0;
         status_in = STATUS_OK;
      end
      if (cmd.srch_issue) begin
         mid_in = mid_calc;
      end
      if (cmd.srch_cmp) begin
         if (key_ff == rd_data_ff) begin
            hit_in = 1'b1;
            pos_in = mid_ff;
         end else if (key_ff < rd_data_ff) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff + CW'(1);
         end
      end
      if (cmd.srch_miss) begin
         pos_in = lo_ff;
      end
      if (cmd.mark_dup) begin
         status_in = STATUS_DUP;
      end
      if (cmd.mark_full) begin
         status_in = STATUS_FULL;
      end
      if (cmd.shift_init) begin
         idx_in  = used_ff;
         pend_in = 1'b0;
      end
      // move entries up one slot, reading below while writing the previous read above
      if (cmd.shift_step) begin
         pend_in = shift_go;
         if (shift_go) begin
            wdst_in = idx_ff;
            idx_in  = shift_src;
         end
      end
      if (cmd.key_write) begin
         used_in = used_ff + CW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = hit_ff;
         rsp_pos_in    = POS_BITS'(pos_ff);
         rsp_status_in = status_ff;
         rsp_count_in  = COUNT_BITS'(used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      mode_ff       <= mode_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      pos_ff        <= pos_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      wdst_ff       <= wdst_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign stat.range_open = lo_ff < hi_ff;
   assign stat.cmp_hit    = key_ff == rd_data_ff;
   assign stat.mode_ins   = mode_ff == MODE_INSERT;
   assign stat.is_hit     = hit_ff;
   assign stat.table_full = used_ff == CW'(TABLE_DEPTH);
   assign stat.shift_done = ~shift_go & ~pend_ff;
   assign stat.out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - POS_BITS - STATUS_BITS - COUNT_BITS){1'b0}},
                        rsp_count_ff, rsp_status_ff, rsp_pos_ff};

endmodule

### hw/rtl/slt_ctrl.sv
// controller state machine of the sorted label table
`timescale 1ns / 1ps

module slt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  slt_pkg::slt_stat_type stat,
   output slt_pkg::slt_cmd_type  cmd
);
   import slt_pkg::*;

   slt_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = stat.range_open ? ST_COMPARE : ST_DECIDE;
         end
         ST_COMPARE: begin
            state_in = stat.cmp_hit ? ST_DECIDE : ST_SEARCH;
         end
         ST_DECIDE: begin
            if (!stat.mode_ins || stat.is_hit || stat.table_full) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (stat.shift_done) state_in = ST_KEY;
         end
         ST_KEY: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is held
            req_tready = ~reset;
            cmd.load   = req_tvalid & ~reset;
         end
         ST_SEARCH: begin
            cmd.srch_issue = stat.range_open;
            cmd.srch_miss  = ~stat.range_open;
         end
         ST_COMPARE: begin
            cmd.srch_cmp = 1'b1;
         end
         ST_DECIDE: begin
            // duplicate check comes before the full check
            if (stat.mode_ins) begin
               if (stat.is_hit) begin
                  cmd.mark_dup = 1'b1;
               end else if (stat.table_full) begin
                  cmd.mark_full = 1'b1;
               end else begin
                  cmd.shift_init = 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
         end
         ST_KEY: begin
            cmd.key_write = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### verif/testbench.sv
// testbench for the sorted label table: directed and random lookups and inserts, checked per item
`timescale 1ns / 1ps

module testbench;
   import slt_pkg::*;

   localparam int DEPTH        = 256;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic                   found;
      logic [POS_BITS-1:0]    position;
      slt_status_type         status;
      logic [COUNT_BITS-1:0]  entry_count;
   } table_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [KEY_BITS-1:0]      req_tdata = '0;    // [31:0] key_label
   logic                     req_tuser = 1'b0;  // [0] mode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // [8:0] position, [10:9] status,
                                                // [19:11] entry_count, rest zero
   logic                     rsp_tuser;         // [0] found

   // behavioral copy of the table
   logic [KEY_BITS-1:0] held_labels [DEPTH];
   int                  held_count = 0;
   table_reply_type     expected_replies [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int fail_count     = 0;

   int n_items = 0, n_lookup_hits = 0, n_lookup_misses = 0;
   int n_inserted = 0, n_dup = 0, n_full = 0;

   sorted_label_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // binary search, then sorted insert; updates the copy and returns the reply
   function automatic table_reply_type predict_table_op(input logic mode,
                                                        input logic [KEY_BITS-1:0] key);
      int              lo, hi, mid, i;
      bit              hit;
      table_reply_type r;
      lo  = 0;
      hi  = held_count;
      hit = 1'b0;
      while (lo < hi && !hit) begin
         mid = lo + (hi - lo) / 2;
         if (held_labels[mid] == key) begin
            hit = 1'b1;
            lo  = mid;
         end else if (key < held_labels[mid]) begin
            hi = mid;
         end else begin
            lo = mid + 1;
         end
      end
      r.found    = hit;
      r.position = POS_BITS'(lo);
      r.status   = STATUS_OK;
      n_items++;
      if (mode == MODE_INSERT) begin
         if (hit) begin
            r.status = STATUS_DUP;
            n_dup++;
         end else if (held_count >= DEPTH) begin
            r.status = STATUS_FULL;
            n_full++;
         end else begin
            for (i = held_count; i > lo; i--)
               held_labels[i] = held_labels[i-1];
            held_labels[lo] = key;
            held_count++;
            n_inserted++;
         end
      end else if (hit) begin
         n_lookup_hits++;
      end else begin
         n_lookup_misses++;
      end
      r.entry_count = COUNT_BITS'(held_count);
      return r;
   endfunction

   // mostly held labels and their neighbors, the rest fully random
   function automatic logic [KEY_BITS-1:0] choose_key(input bit for_insert);
      int                  r;
      logic [KEY_BITS-1:0] key;
      r   = $urandom_range(99);
      key = $urandom;
      if (held_count > 0 && r < 40)
         key = held_labels[$urandom_range(held_count - 1)];
      else if (held_count > 0 && r < 55)
         key = held_labels[$urandom_range(held_count - 1)] + ($urandom_range(1) ? 1 : -1);
      // all-ones stays out of the table so a full-table miss can land past the last entry
      if (for_insert && key == '1)
         key = KEY_BITS'(32'h8000_0001);
      return key;
   endfunction

   task automatic send_item(input logic mode, input logic [KEY_BITS-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_replies.push_back(predict_table_op(mode, key));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   task automatic test_empty_table();
      set_idling(0, 0);
      send_item(MODE_LOOKUP, '0);
      send_item(MODE_LOOKUP, '1);
      send_item(MODE_LOOKUP, KEY_BITS'(32'h1234_5678));
      send_item(MODE_INSERT, KEY_BITS'(32'h8000_0000));
      wait_drained();
   endtask

   task automatic test_edge_labels();
      send_item(MODE_INSERT, '0);                         // goes in front, shifts one
      send_item(MODE_INSERT, KEY_BITS'(32'hFFFF_FFFE));   // appended
      send_item(MODE_LOOKUP, '0);                         // hit at entry zero
      send_item(MODE_INSERT, '0);
      send_item(MODE_INSERT, KEY_BITS'(32'hFFFF_FFFE));
      send_item(MODE_LOOKUP, KEY_BITS'(32'h0000_0001));
      send_item(MODE_INSERT, KEY_BITS'(32'h0000_0001));
      send_item(MODE_LOOKUP, KEY_BITS'(32'h7FFF_FFFF));
      send_item(MODE_INSERT, KEY_BITS'(32'h5555_5555));
      send_item(MODE_INSERT, KEY_BITS'(32'hAAAA_AAAA));
      send_item(MODE_LOOKUP, KEY_BITS'(32'h8000_0000));
      send_item(MODE_LOOKUP, '1);                         // miss past the last entry
      wait_drained();
   endtask

   task automatic test_random_traffic(input int items, input int send_pct,
                                      input int recv_pct, input int insert_pct);
      logic mode;
      set_idling(send_pct, recv_pct);
      repeat (items) begin
         mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_LOOKUP;
         send_item(mode, choose_key(mode == MODE_INSERT));
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      hold_requests <= hold_requests + 1;
      repeat (12)
         send_item($urandom_range(1) ? MODE_INSERT : MODE_LOOKUP, choose_key(1'b1));
      wait_drained();
   endtask

   task automatic test_fill_table();
      set_idling(24, 24);
      while (held_count < DEPTH)
         send_item(MODE_INSERT, choose_key(1'b1));
      wait_drained();
   endtask

   task automatic test_full_table();
      set_idling(0, 0);
      send_item(MODE_INSERT, '1);                          // rejected, position past the end
      send_item(MODE_LOOKUP, '1);
      send_item(MODE_INSERT, '0);                          // duplicate wins over full
      send_item(MODE_LOOKUP, '0);
      send_item(MODE_LOOKUP, held_labels[DEPTH-1]);
      send_item(MODE_INSERT, held_labels[100]);
      send_item(MODE_INSERT, KEY_BITS'(32'h0000_0002));
      wait_drained();
   endtask

   // long receiver hold-offs are counted here, otherwise random stalls
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_replies
      table_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $error("result item with none expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[8:0] !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_tdata[8:0]);
               fail_count++;
            end
            if (rsp_tdata[10:9] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[10:9]);
               fail_count++;
            end
            if (rsp_tdata[19:11] !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_tdata[19:11]);
               fail_count++;
            end
            if (rsp_tdata[RSP_DATA_BITS-1:20] !== '0) begin
               $error("padding: expected 0, got %h", rsp_tdata[RSP_DATA_BITS-1:20]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_edge_labels();
      test_random_traffic(350, 0, 0, 25);
      test_random_traffic(350, 46, 0, 25);
      test_backpressure();
      test_random_traffic(350, 0, 46, 25);
      test_random_traffic(350, 24, 24, 25);
      test_fill_table();
      test_full_table();
      test_random_traffic(250, 24, 24, 50);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $error("%0d expected results never arrived", expected_replies.size());
         fail_count++;
      end
      $display("run covered %0d items: %0d lookup hits, %0d lookup misses, %0d inserts stored",
               n_items, n_lookup_hits, n_lookup_misses, n_inserted);
      $display("rejected inserts: %0d duplicate, %0d with the table full; %0d labels held",
               n_dup, n_full, held_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("timeout with %0d results outstanding", expected_replies.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
